### sv/bhwc_pkg.sv
// Shared constants and types for the bounded histogram window counter.
`default_nettype none
package bhwc_pkg;

  localparam int ALPHABET   = 26;
  localparam int MAX_WINDOW = 1024;

  localparam int LETTER_W = 5;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 11;
  localparam int TOTAL_W  = 63;
  localparam int ALPH_W   = $clog2(ALPHABET);
  localparam int PTR_W    = $clog2(MAX_WINDOW);
  localparam int LEN_W    = $clog2(MAX_WINDOW + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUDGET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEXT   = 2'd2;

  // Window letter store request: one write port, one read port.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [ALPH_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

endpackage
`default_nettype wire

### sv/bounded_histogram_window_counter_top.sv
// Top level of the bounded histogram window counter.
//
// Channel | Dir | Handshake          | Payload
// in      | in  | in_tvalid/tready   | tdata: letter; tuser: func
// out     | out | out_tvalid/tready  | tdata: total_count, window_length
// cfg     | in  | cfg_wen            | cfg_wdata: max_window
//
// Clear, budget and unused items are handled in S_IDLE on acceptance. A
// text item passes through S_CAP and S_CHK, with an S_POPW step for each letter
// popped from the window: each pop waits for the registered read of the window
// letter store before its count is decremented. A text item that empties the
// window goes straight to S_DONE. rst_n clears all control state; letter store
// contents stay undefined. A result waiting on out_tready holds the next text
// item in its last state, with in_tready low, until the output register frees.
`default_nettype none
module bounded_histogram_window_counter_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [bhwc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [4:0] letter
  input  wire logic [bhwc_pkg::FUNC_W-1:0]        in_tuser,   // [1:0] func
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [bhwc_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [62:0] total_count,
                                                              // [73:63] window_length
  input  wire logic                               cfg_wen,
  input  wire logic [bhwc_pkg::CFG_W-1:0]         cfg_wdata   // [10:0] max_window
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CAP  = 5'b00010,
    S_POPW = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [bhwc_pkg::LEN_W-1:0] LEN_MAX = bhwc_pkg::LEN_W'(bhwc_pkg::MAX_WINDOW);
  localparam logic [bhwc_pkg::PTR_W-1:0] PTR_LAST =
    bhwc_pkg::PTR_W'(bhwc_pkg::MAX_WINDOW - 1);

  state_t state_r, state_nxt;
  logic   ret_chk_r, ret_chk_nxt;

  logic [bhwc_pkg::CFG_W-1:0]   max_window_r;
  logic [bhwc_pkg::LEN_W-1:0]   bh_r  [bhwc_pkg::ALPHABET];
  logic [bhwc_pkg::LEN_W-1:0]   bh_nxt[bhwc_pkg::ALPHABET];
  logic [bhwc_pkg::LEN_W-1:0]   wh_r  [bhwc_pkg::ALPHABET];
  logic [bhwc_pkg::LEN_W-1:0]   wh_nxt[bhwc_pkg::ALPHABET];
  logic [bhwc_pkg::PTR_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [bhwc_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [bhwc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [bhwc_pkg::ALPH_W-1:0]  cur_r, cur_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [bhwc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  bhwc_pkg::ram_req_t           ram_req;
  logic [bhwc_pkg::ALPH_W-1:0]  ram_rdata;

  logic                         in_acc;
  logic [bhwc_pkg::LETTER_W-1:0] in_letter;
  logic                         letter_ok;
  logic [bhwc_pkg::ALPH_W-1:0]  in_idx;
  logic [bhwc_pkg::LEN_W-1:0]   cap;
  logic                         out_free;
  logic [bhwc_pkg::TOTAL_W-1:0] total_sum;

  bhwc_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_letter  = in_tdata[bhwc_pkg::LETTER_W-1:0];
  assign letter_ok  = 32'(in_letter) < 32'(bhwc_pkg::ALPHABET);
  assign in_idx     = bhwc_pkg::ALPH_W'(in_letter);
  assign cap        = (32'(max_window_r) < 32'(bhwc_pkg::MAX_WINDOW)) ?
                      bhwc_pkg::LEN_W'(max_window_r) : LEN_MAX;
  assign out_free   = !out_valid_r || out_tready;
  assign total_sum  = total_r + bhwc_pkg::TOTAL_W'(len_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    ret_chk_nxt   = ret_chk_r;
    bh_nxt        = bh_r;
    wh_nxt        = wh_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    total_nxt     = total_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = tail_r;
    ram_req.wdata = cur_r;
    ram_req.raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            bhwc_pkg::FUNC_CLEAR: begin
              for (int i = 0; i < bhwc_pkg::ALPHABET; i++) begin
                bh_nxt[i] = '0;
                wh_nxt[i] = '0;
              end
              head_nxt  = '0;
              tail_nxt  = '0;
              len_nxt   = '0;
              total_nxt = '0;
            end
            bhwc_pkg::FUNC_BUDGET: begin
              if (letter_ok && bh_r[in_idx] < LEN_MAX) begin
                bh_nxt[in_idx] = bh_r[in_idx] + 1'b1;
              end
            end
            bhwc_pkg::FUNC_TEXT: begin
              cur_nxt = in_idx;
              if (cap == '0 || !letter_ok || bh_r[in_idx] == '0) begin
                // Drop the whole window at once; total is unchanged.
                for (int i = 0; i < bhwc_pkg::ALPHABET; i++) begin
                  wh_nxt[i] = '0;
                end
                head_nxt  = tail_r;
                len_nxt   = '0;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_CAP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CAP: begin
        if (len_r >= cap) begin
          // Head letter read is under way; apply it next cycle.
          ret_chk_nxt = 1'b0;
          state_nxt   = S_POPW;
        end else begin
          ram_req.we  = 1'b1;
          tail_nxt    = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
          wh_nxt[cur_r] = wh_r[cur_r] + 1'b1;
          len_nxt     = len_r + 1'b1;
          state_nxt   = S_CHK;
        end
      end

      S_POPW: begin
        if (wh_r[ram_rdata] != '0) begin
          wh_nxt[ram_rdata] = wh_r[ram_rdata] - 1'b1;
        end
        head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
        len_nxt   = len_r - 1'b1;
        state_nxt = ret_chk_r ? S_CHK : S_CAP;
      end

      S_CHK: begin
        if (len_r != '0 && wh_r[cur_r] > bh_r[cur_r]) begin
          ret_chk_nxt = 1'b1;
          state_nxt   = S_POPW;
        end else begin
          total_nxt = total_sum;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {6'b0, len_r, total_sum};
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, len_r, total_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_chk_r    <= 1'b0;
      max_window_r <= bhwc_pkg::CFG_W'(1024);
      head_r       <= '0;
      tail_r       <= '0;
      len_r        <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < bhwc_pkg::ALPHABET; i++) begin
        bh_r[i] <= '0;
        wh_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ret_chk_r   <= ret_chk_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      bh_r        <= bh_nxt;
      wh_r        <= wh_nxt;
      if (cfg_wen) begin
        max_window_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

### sv/bhwc_ram.sv
// Window letter store: one write and one registered read per cycle.
`default_nettype none
module bhwc_ram (
  input  wire logic                      clk,
  input  wire bhwc_pkg::ram_req_t        req,
  output logic [bhwc_pkg::ALPH_W-1:0]    rdata
);

  logic [bhwc_pkg::ALPH_W-1:0] mem [bhwc_pkg::MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire
